[src/uos_pkg.sv]
// ----------------------------------------------------------------------------
// Ultrasonic occupancy sensor package
// Shared constants, phase codes and structures for the sensor core.
// ----------------------------------------------------------------------------
package uos_pkg;

    localparam int SENSORS      = 2;
    localparam int SENSOR_IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;

    localparam int INTERVAL_W   = 24;
    localparam int THRESHOLD_W  = 11;
    localparam int MAX_ECHO_W   = 16;
    localparam int TRIG_W       = 4;
    localparam int ECHO_CNT_W   = 17;
    localparam int DIST_W       = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;

    localparam logic [INTERVAL_W-1:0]  RESET_INTERVAL   = 24'd500000;
    localparam logic [THRESHOLD_W-1:0] RESET_THRESHOLD  = 11'd5;
    localparam logic [MAX_ECHO_W-1:0]  RESET_MAX_ECHO   = 16'd23200;
    localparam logic [TRIG_W-1:0]      RESET_TRIG_WIDTH = 4'd10;
    localparam logic [DIST_W-1:0]      RESET_DISTANCE   = 11'd999;

    // Division by 58 as a multiply by a scaled reciprocal.
    localparam int                RECIP_SHIFT = 22;
    localparam int                RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP_MULT  = 17'd72316;
    localparam int                PROD_W      = MAX_ECHO_W + RECIP_W;

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_WAIT_HIGH = 2'd1;
    localparam logic [1:0] PH_WAIT_LOW  = 2'd2;
    localparam logic [1:0] PH_DONE      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ECHO   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_WIDTH = 2'd3;

    typedef struct packed {
        logic              rejected;
        logic [DIST_W-1:0] cm;
        logic              occ_now;
    } t_eval;

    typedef struct packed {
        logic [SENSORS-1:0]      trigger_levels;
        logic [SENSORS-1:0]      led_levels;
        logic                    report_valid;
        logic [SENSOR_IDX_W-1:0] report_sensor;
        logic                    report_rejected;
        logic [DIST_W-1:0]       report_distance_cm;
        logic                    report_occupied;
        logic                    report_changed;
    } t_result;

endpackage

[src/uos_eval.sv]
// ----------------------------------------------------------------------------
// Echo width evaluation
// Checks an echo width against the limit, converts it to centimeters and
// compares the distance with the occupancy threshold.
// ----------------------------------------------------------------------------
module uos_eval
    import uos_pkg::*;
(
    input  logic [ECHO_CNT_W-1:0]  i_width,
    input  logic [MAX_ECHO_W-1:0]  i_max_echo,
    input  logic [THRESHOLD_W-1:0] i_threshold,
    output t_eval                  o_eval
);

    logic [PROD_W-1:0] w_prod;

    assign w_prod = PROD_W'(i_width[MAX_ECHO_W-1:0]) * PROD_W'(RECIP_MULT);

    always_comb begin
        o_eval.rejected = (i_width == '0) ||
                          (i_width > {1'b0, i_max_echo});
        o_eval.cm       = w_prod[RECIP_SHIFT +: DIST_W];
        o_eval.occ_now  = (w_prod[RECIP_SHIFT +: DIST_W] <= i_threshold);
    end

endmodule

[src/uos_lane.sv]
// ----------------------------------------------------------------------------
// Sensor lane
// Trigger pulse, echo timing and stored measurement of one sensor.
// ----------------------------------------------------------------------------
module uos_lane
    import uos_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_grant,
    input  logic                  i_echo,
    input  logic                  i_round,
    input  logic [TRIG_W-1:0]     i_trig_width,
    input  logic [MAX_ECHO_W-1:0] i_max_echo,
    input  t_eval                 i_eval,
    output logic                  o_done,
    output logic [ECHO_CNT_W-1:0] o_width,
    output logic [DIST_W-1:0]     o_dist,
    output logic                  o_occ,
    output logic                  o_occ_next,
    output logic                  o_trig_next
);

    logic [1:0]            r_phase, n_phase;
    logic [TRIG_W-1:0]     r_pulse, n_pulse;
    logic [ECHO_CNT_W-1:0] r_width, n_width;
    logic [DIST_W-1:0]     r_dist, n_dist;
    logic                  r_occ, n_occ;
    logic [ECHO_CNT_W-1:0] w_limit;

    assign w_limit = ECHO_CNT_W'(i_max_echo) + ECHO_CNT_W'(1);

    always_comb begin
        n_pulse = (r_pulse != '0) ? r_pulse - TRIG_W'(1) : '0;
        n_phase = r_phase;
        n_width = r_width;
        n_dist  = r_dist;
        n_occ   = r_occ;

        if ((r_phase == PH_DONE) && i_grant) begin
            n_phase = PH_IDLE;
            if (!i_eval.rejected) begin
                n_dist = i_eval.cm;
                n_occ  = i_eval.occ_now;
            end
        end

        case (r_phase)
            PH_WAIT_HIGH: begin
                if (i_echo) begin
                    n_width = ECHO_CNT_W'(1);
                    n_phase = PH_WAIT_LOW;
                end
            end
            PH_WAIT_LOW: begin
                if (i_echo) begin
                    if (r_width < w_limit) begin
                        n_width = r_width + ECHO_CNT_W'(1);
                    end
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        if (i_round && (n_phase == PH_IDLE)) begin
            n_phase = PH_WAIT_HIGH;
            n_pulse = i_trig_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pulse <= '0;
            r_width <= '0;
            r_dist  <= RESET_DISTANCE;
            r_occ   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pulse <= n_pulse;
            r_width <= n_width;
            r_dist  <= n_dist;
            r_occ   <= n_occ;
        end
    end

    assign o_done      = (r_phase == PH_DONE);
    assign o_width     = r_width;
    assign o_dist      = r_dist;
    assign o_occ       = r_occ;
    assign o_occ_next  = n_occ;
    assign o_trig_next = (n_pulse != '0);

endmodule

[src/uos_out_buf.sv]
// ----------------------------------------------------------------------------
// Output buffer
// Output register with a skid stage so that a stalled receiver does not
// block the transaction already in flight on the input side.
// ----------------------------------------------------------------------------
module uos_out_buf
    import uos_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_take;

    assign w_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !w_take) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[src/ultrasonic_occupancy_sensor_core.sv]
// ----------------------------------------------------------------------------
// Ultrasonic occupancy sensor core
// Trigger rounds, echo timing and occupancy reporting for a set of sensors.
// ----------------------------------------------------------------------------
// Each input transaction is one microsecond tick carrying the echo level of
// every sensor. Each tick produces exactly one output transaction holding the
// trigger and LED drive of all sensors and, when a sensor finished, the report
// of the lowest-numbered finished sensor.
// The input channel accepts when i_valid is high and o_stall is low. The
// output channel delivers when o_valid is high and i_stall is low.
// The result of a tick is registered in the output buffer. A new tick can
// be accepted every cycle while o_stall is low; all work for a tick is done
// by one level of logic between the state registers and the output register.
// When the receiver stalls, the output register holds its transaction and
// one more tick is caught in a skid register; o_stall then rises until the
// skid register drains.
// Configuration writes go through i_cfg_valid with o_cfg_ready always high.
// The user must make them only while the core is idle (not enforced here).
// Synchronous reset loads the default configuration, clears the interval
// counter, sets every sensor idle with a distance of 999 cm and empties the
// output buffer.
// ----------------------------------------------------------------------------
module ultrasonic_occupancy_sensor_core
    import uos_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SENSORS-1:0]      i_echo_levels,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [SENSORS-1:0]      o_trigger_levels,
    output logic [SENSORS-1:0]      o_led_levels,
    output logic                    o_report_valid,
    output logic [SENSOR_IDX_W-1:0] o_report_sensor,
    output logic                    o_report_rejected,
    output logic [DIST_W-1:0]       o_report_distance_cm,
    output logic                    o_report_occupied,
    output logic                    o_report_changed,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic [INTERVAL_W-1:0]  r_interval;
    logic [THRESHOLD_W-1:0] r_threshold;
    logic [MAX_ECHO_W-1:0]  r_max_echo;
    logic [TRIG_W-1:0]      r_trig_width;
    logic [INTERVAL_W-1:0]  r_count, n_count;

    logic                   w_step;
    logic                   w_round;
    logic [INTERVAL_W:0]    w_count_inc;
    logic [INTERVAL_W-1:0]  w_period;

    logic [SENSORS-1:0]     w_done;
    logic [SENSORS-1:0]     w_grant;
    logic [SENSORS-1:0]     w_occ_next;
    logic [SENSORS-1:0]     w_trig_next;
    logic [SENSORS-1:0]     w_occ;
    logic [ECHO_CNT_W-1:0]  w_width [SENSORS];
    logic [DIST_W-1:0]      w_dist  [SENSORS];

    logic                    w_any;
    logic [SENSOR_IDX_W-1:0] w_sel;
    t_eval                   w_eval;
    t_result                 w_result;
    t_result                 w_out;

    assign o_cfg_ready = 1'b1;
    assign w_step      = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval   <= RESET_INTERVAL;
            r_threshold  <= RESET_THRESHOLD;
            r_max_echo   <= RESET_MAX_ECHO;
            r_trig_width <= RESET_TRIG_WIDTH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_INTERVAL:   r_interval   <= i_cfg_data[INTERVAL_W-1:0];
                CFG_THRESHOLD:  r_threshold  <= i_cfg_data[THRESHOLD_W-1:0];
                CFG_MAX_ECHO:   r_max_echo   <= i_cfg_data[MAX_ECHO_W-1:0];
                CFG_TRIG_WIDTH: r_trig_width <= i_cfg_data[TRIG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_period    = (r_interval == '0) ? INTERVAL_W'(1) : r_interval;
    assign w_count_inc = {1'b0, r_count} + (INTERVAL_W+1)'(1);
    assign w_round     = (w_count_inc >= {1'b0, w_period});
    assign n_count     = w_round ? '0 : w_count_inc[INTERVAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_step) begin
            r_count <= n_count;
        end
    end

    always_comb begin
        w_any   = 1'b0;
        w_sel   = '0;
        w_grant = '0;
        for (int i = 0; i < SENSORS; i++) begin
            if (w_done[i] && !w_any) begin
                w_any      = 1'b1;
                w_sel      = SENSOR_IDX_W'(i);
                w_grant[i] = 1'b1;
            end
        end
    end

    uos_eval u_eval (
        .i_width     (w_width[w_sel]),
        .i_max_echo  (r_max_echo),
        .i_threshold (r_threshold),
        .o_eval      (w_eval)
    );

    for (genvar g = 0; g < SENSORS; g++) begin : g_lane
        uos_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_step       (w_step),
            .i_grant      (w_grant[g]),
            .i_echo       (i_echo_levels[g]),
            .i_round      (w_round),
            .i_trig_width (r_trig_width),
            .i_max_echo   (r_max_echo),
            .i_eval       (w_eval),
            .o_done       (w_done[g]),
            .o_width      (w_width[g]),
            .o_dist       (w_dist[g]),
            .o_occ        (w_occ[g]),
            .o_occ_next   (w_occ_next[g]),
            .o_trig_next  (w_trig_next[g])
        );
    end

    always_comb begin
        w_result                    = '0;
        w_result.trigger_levels     = w_trig_next;
        w_result.led_levels         = w_occ_next;
        if (w_any) begin
            w_result.report_valid    = 1'b1;
            w_result.report_sensor   = w_sel;
            w_result.report_rejected = w_eval.rejected;
            if (w_eval.rejected) begin
                w_result.report_distance_cm = w_dist[w_sel];
                w_result.report_occupied    = w_occ[w_sel];
            end else begin
                w_result.report_distance_cm = w_eval.cm;
                w_result.report_occupied    = w_eval.occ_now;
                w_result.report_changed     = (w_eval.occ_now != w_occ[w_sel]);
            end
        end
    end

    uos_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_step),
        .i_data  (w_result),
        .o_full  (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (w_out)
    );

    assign o_trigger_levels     = w_out.trigger_levels;
    assign o_led_levels         = w_out.led_levels;
    assign o_report_valid       = w_out.report_valid;
    assign o_report_sensor      = w_out.report_sensor;
    assign o_report_rejected    = w_out.report_rejected;
    assign o_report_distance_cm = w_out.report_distance_cm;
    assign o_report_occupied    = w_out.report_occupied;
    assign o_report_changed     = w_out.report_changed;

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ultrasonic occupancy sensor core testbench
// Drives echo levels one tick per transaction, predicts every output
// transaction from its own model of the trigger rounds and echo timing, and
// compares each output field against that prediction under random idling,
// receiver stalls and a long hold-off that fills the core.
// ----------------------------------------------------------------------------
module testbench;
    import uos_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int CM_DIVISOR  = 58;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [SENSORS-1:0]      i_echo_levels = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [SENSORS-1:0]      o_trigger_levels;
    logic [SENSORS-1:0]      o_led_levels;
    logic                    o_report_valid;
    logic [SENSOR_IDX_W-1:0] o_report_sensor;
    logic                    o_report_rejected;
    logic [DIST_W-1:0]       o_report_distance_cm;
    logic                    o_report_occupied;
    logic                    o_report_changed;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    ultrasonic_occupancy_sensor_core u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_echo_levels        (i_echo_levels),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_trigger_levels     (o_trigger_levels),
        .o_led_levels         (o_led_levels),
        .o_report_valid       (o_report_valid),
        .o_report_sensor      (o_report_sensor),
        .o_report_rejected    (o_report_rejected),
        .o_report_distance_cm (o_report_distance_cm),
        .o_report_occupied    (o_report_occupied),
        .o_report_changed     (o_report_changed),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [INTERVAL_W-1:0]  cfg_interval;
    logic [THRESHOLD_W-1:0] cfg_threshold;
    logic [MAX_ECHO_W-1:0]  cfg_max_echo;
    logic [TRIG_W-1:0]      cfg_trig_width;

    int unsigned       round_ticks;
    logic [1:0]        phase [SENSORS];
    int unsigned       echo_ticks [SENSORS];
    int unsigned       pulse_left [SENSORS];
    logic [DIST_W-1:0] stored_cm [SENSORS];
    logic              occupied [SENSORS];

    t_result expected_ticks [$];

    int unsigned rise_delay [SENSORS];
    int unsigned high_left [SENSORS];
    int          noise_pct = 0;
    int          miss_pct = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          stall_run = 0;
    int          hold_cycles = 0;
    int          fail_count = 0;
    int          cycle_count = 0;

    function automatic void reset_predictor();
        cfg_interval   = RESET_INTERVAL;
        cfg_threshold  = RESET_THRESHOLD;
        cfg_max_echo   = RESET_MAX_ECHO;
        cfg_trig_width = RESET_TRIG_WIDTH;
        round_ticks    = 0;
        for (int i = 0; i < SENSORS; i++) begin
            phase[i]      = PH_IDLE;
            echo_ticks[i] = 0;
            pulse_left[i] = 0;
            stored_cm[i]  = RESET_DISTANCE;
            occupied[i]   = 1'b0;
            rise_delay[i] = 0;
            high_left[i]  = 0;
        end
    endfunction

    function automatic void predict_tick(input logic [SENSORS-1:0] echo);
        t_result     r;
        int unsigned limit;
        int unsigned period;
        int unsigned cm;
        logic        now_occ;
        bit          found;
        r = '0;
        found = 1'b0;
        limit = 32'(cfg_max_echo) + 1;
        for (int i = 0; i < SENSORS; i++) begin
            if (pulse_left[i] != 0) begin
                pulse_left[i]--;
            end
        end
        for (int i = 0; i < SENSORS; i++) begin
            if (!found && phase[i] == PH_DONE) begin
                found = 1'b1;
                phase[i] = PH_IDLE;
                r.report_valid = 1'b1;
                r.report_sensor = SENSOR_IDX_W'(i);
                if (echo_ticks[i] == 0 || echo_ticks[i] > 32'(cfg_max_echo)) begin
                    r.report_rejected = 1'b1;
                end else begin
                    cm = echo_ticks[i] / CM_DIVISOR;
                    now_occ = (cm <= 32'(cfg_threshold));
                    r.report_changed = (now_occ != occupied[i]);
                    stored_cm[i] = DIST_W'(cm);
                    occupied[i] = now_occ;
                end
                r.report_distance_cm = stored_cm[i];
                r.report_occupied = occupied[i];
            end
        end
        for (int i = 0; i < SENSORS; i++) begin
            if (phase[i] == PH_WAIT_HIGH) begin
                if (echo[i]) begin
                    echo_ticks[i] = 1;
                    phase[i] = PH_WAIT_LOW;
                end
            end else if (phase[i] == PH_WAIT_LOW) begin
                if (echo[i]) begin
                    if (echo_ticks[i] < limit) begin
                        echo_ticks[i]++;
                    end
                end else begin
                    phase[i] = PH_DONE;
                end
            end
        end
        period = (cfg_interval == '0) ? 1 : 32'(cfg_interval);
        round_ticks++;
        if (round_ticks >= period) begin
            round_ticks = 0;
            for (int i = 0; i < SENSORS; i++) begin
                if (phase[i] == PH_IDLE) begin
                    phase[i] = PH_WAIT_HIGH;
                    pulse_left[i] = 32'(cfg_trig_width);
                end
            end
        end
        for (int i = 0; i < SENSORS; i++) begin
            r.trigger_levels[i] = (pulse_left[i] != 0);
            r.led_levels[i] = occupied[i];
        end
        expected_ticks.push_back(r);
    endfunction

    function automatic int unsigned pick_width();
        int unsigned cap;
        int unsigned bound;
        int unsigned w;
        int unsigned r;
        cap = (cfg_max_echo > 257) ? 260 : 32'(cfg_max_echo) + 3;
        bound = CM_DIVISOR * (32'(cfg_threshold) + 1);
        r = $urandom_range(99);
        if (r < 35) begin
            w = $urandom_range(1, 12);
        end else if (r < 55) begin
            w = bound - 2 + $urandom_range(0, 3);
        end else if (r < 70) begin
            w = 32'(cfg_max_echo) - 1 + $urandom_range(0, 4);
        end else begin
            w = $urandom_range(1, cap);
        end
        if (w > cap) begin
            w = cap;
        end
        if (w == 0) begin
            w = 1;
        end
        return w;
    endfunction

    function automatic int unsigned pick_delay();
        if ($urandom_range(99) < miss_pct) begin
            return $urandom_range(20, 60);
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [SENSORS-1:0] next_echo();
        logic [SENSORS-1:0] lv;
        lv = '0;
        for (int i = 0; i < SENSORS; i++) begin
            if (high_left[i] != 0) begin
                lv[i] = 1'b1;
                high_left[i]--;
            end else if (phase[i] == PH_WAIT_HIGH && rise_delay[i] == 0) begin
                lv[i] = 1'b1;
                high_left[i] = pick_width() - 1;
                rise_delay[i] = pick_delay();
            end else begin
                if (phase[i] == PH_WAIT_HIGH) begin
                    rise_delay[i]--;
                end
                lv[i] = ($urandom_range(99) < noise_pct);
            end
        end
        return lv;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_ticks.size() == 0) begin
                fail_count++;
                $display("%0t: output transaction with no tick pending", $time);
            end else begin
                want = expected_ticks.pop_front();
                check_field("trigger_levels", 32'(want.trigger_levels),
                            32'(o_trigger_levels));
                check_field("led_levels", 32'(want.led_levels), 32'(o_led_levels));
                check_field("report_valid", 32'(want.report_valid), 32'(o_report_valid));
                check_field("report_sensor", 32'(want.report_sensor),
                            32'(o_report_sensor));
                check_field("report_rejected", 32'(want.report_rejected),
                            32'(o_report_rejected));
                check_field("report_distance_cm", 32'(want.report_distance_cm),
                            32'(o_report_distance_cm));
                check_field("report_occupied", 32'(want.report_occupied),
                            32'(o_report_occupied));
                check_field("report_changed", 32'(want.report_changed),
                            32'(o_report_changed));
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall = 1'b1;
            hold_cycles--;
        end else if (stall_run > 0) begin
            i_stall = 1'b1;
            stall_run--;
        end else if ($urandom_range(99) < stall_pct) begin
            i_stall = 1'b1;
            stall_run = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        end else begin
            i_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ultrasonic_occupancy_sensor_core verification failed");
            $finish;
        end
    end

    task automatic send_tick(input logic [SENSORS-1:0] echo);
        i_echo_levels = echo;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predict_tick(echo);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        if ($urandom_range(99) < gap_pct) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
            i_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic run_ticks(input int count);
        repeat (count) begin
            send_tick(next_echo());
            idle_gap();
        end
    endtask

    task automatic drain_results();
        i_valid = 1'b0;
        while (expected_ticks.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_index = idx;
        i_cfg_data = value;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_INTERVAL:   cfg_interval = value[INTERVAL_W-1:0];
            CFG_THRESHOLD:  cfg_threshold = value[THRESHOLD_W-1:0];
            CFG_MAX_ECHO:   cfg_max_echo = value[MAX_ECHO_W-1:0];
            CFG_TRIG_WIDTH: cfg_trig_width = value[TRIG_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(input int unsigned interval, input int unsigned threshold,
                             input int unsigned max_echo, input int unsigned trig_width);
        drain_results();
        write_reg(CFG_INTERVAL, CFG_DATA_W'(interval));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(threshold));
        write_reg(CFG_MAX_ECHO, CFG_DATA_W'(max_echo));
        write_reg(CFG_TRIG_WIDTH, CFG_DATA_W'(trig_width));
    endtask

    task automatic send_sequence(input logic [SENSORS-1:0] seq [$]);
        foreach (seq[k]) begin
            send_tick(seq[k]);
        end
    endtask

    task automatic test_idle_after_reset();
        send_sequence('{2'b00, 2'b01, 2'b10});
    endtask

    task automatic test_simultaneous_finish();
        configure(2, 5, 400, 1);
        send_sequence('{2'b00, 2'b00, 2'b11, 2'b11, 2'b00, 2'b00, 2'b00});
    endtask

    task automatic test_special_settings();
        configure(0, 0, 1, 0);
        send_sequence('{2'b01, 2'b00, 2'b11, 2'b11, 2'b11, 2'b00});
        configure(16777215, 1129, 65535, 15);
        send_sequence('{2'b11, 2'b00, 2'b00, 2'b00, 2'b00});
        configure(1, 1129, 65535, 15);
        send_sequence('{2'b00, 2'b11, 2'b11, 2'b00, 2'b00, 2'b00});
    endtask

    task automatic test_random_traffic(input int unsigned interval, input int unsigned threshold,
                                       input int unsigned max_echo, input int unsigned trig_width,
                                       input int count, input int gaps, input int stalls,
                                       input int noise, input int misses);
        configure(interval, threshold, max_echo, trig_width);
        gap_pct = gaps;
        stall_pct = stalls;
        noise_pct = noise;
        miss_pct = misses;
        run_ticks(count);
    endtask

    task automatic test_backpressure();
        configure(5, 2, 300, 3);
        gap_pct = 0;
        stall_pct = 0;
        noise_pct = 5;
        miss_pct = 5;
        run_ticks(20);
        hold_cycles = 60;
        run_ticks(40);
        drain_results();
        gap_pct = 20;
        stall_pct = 20;
        run_ticks(60);
    endtask

    initial begin
        reset_predictor();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_idle_after_reset();
        test_simultaneous_finish();
        test_special_settings();
        test_random_traffic(20, 1, 150, 10, 200, 0, 0, 0, 0);
        test_random_traffic(1, 0, 60, 1, 160, 20, 20, 10, 10);
        test_random_traffic(50, 1129, 65535, 15, 160, 30, 30, 5, 20);
        test_random_traffic(0, 2, 200, 0, 160, 15, 40, 15, 10);
        test_backpressure();
        drain_results();
        repeat (4) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("ultrasonic_occupancy_sensor_core verification clean");
        end else begin
            $display("ultrasonic_occupancy_sensor_core verification failed");
        end
        $finish;
    end

endmodule
